### hdl/splitmix64_ranged_random_assert.svh
// assertion macros for the checker file
`ifndef SPLITMIX64_RANGED_RANDOM_ASSERT_SVH
`define SPLITMIX64_RANGED_RANDOM_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SMRR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smrr assertion failed");

// next-cycle implication, disabled in reset
`define SMRR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smrr assertion failed");

`endif

### hdl/smrr_pkg.sv
package smrr_pkg;

    // mixer constants
    localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;
    localparam int unsigned SHIFT_PRE  = 30;
    localparam int unsigned SHIFT_MID  = 27;
    localparam int unsigned SHIFT_POST = 31;

    // sequencing
    localparam int unsigned MUL_STEPS = 4;
    localparam int unsigned DIV_STEPS = 64;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    // operation codes
    localparam logic [1:0] OP_RAW   = 2'd0;
    localparam logic [1:0] OP_BOUND = 2'd1;
    localparam logic [1:0] OP_RANGE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADV,
        S_PRE,
        S_MULA,
        S_MID,
        S_MULB,
        S_POST,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] bound_count;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
    } t_in;

    typedef struct packed {
        logic [63:0]        raw_word;
        logic signed [31:0] ranged_value;
    } t_out;

    typedef struct packed {
        logic       accept;
        logic       adv;
        logic       pre;
        logic       mul_a;
        logic       mid;
        logic       mul_b;
        logic       post;
        logic       div_step;
        logic       load_out;
        logic [1:0] mul_step;
    } t_cmd;

    typedef struct packed {
        logic adv_ok;
        logic mod_needed;
    } t_stat;

    // true when a 32-bit pattern read as signed is above zero
    function automatic logic positive32(input logic [31:0] v);
        positive32 = (v != 32'd0) && !v[31];
    endfunction

endpackage

### hdl/smrr_datapath.sv
module smrr_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [63:0]      i_cfg_wdata,
    input  smrr_pkg::t_in    i_in,
    input  smrr_pkg::t_cmd   i_cmd,
    output smrr_pkg::t_stat  o_stat,
    output smrr_pkg::t_out   o_out
);

    logic [63:0] r_state;
    logic [63:0] r_z;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [63:0] r_word;
    logic [63:0] r_dvd;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic [31:0] r_lo;
    logic [1:0]  r_op;
    logic        r_adv;
    smrr_pkg::t_out r_out;

    logic [31:0] w_span;
    logic        w_adv_ok;
    logic [63:0] w_k;
    logic [31:0] w_mul_x;
    logic [31:0] w_mul_y;
    logic [63:0] w_prod;
    logic [31:0] w_trial;
    logic        w_ge;
    logic [31:0] w_ranged;

    // span of the range and whether the generator advances
    assign w_span = 32'(i_in.range_high) - 32'(i_in.range_low) + 32'd1;

    always_comb begin
        case (i_in.operation)
            smrr_pkg::OP_RAW:   w_adv_ok = 1'b1;
            smrr_pkg::OP_BOUND: w_adv_ok = smrr_pkg::positive32(32'(i_in.bound_count));
            smrr_pkg::OP_RANGE: w_adv_ok = smrr_pkg::positive32(w_span);
            default:            w_adv_ok = 1'b0;
        endcase
    end

    assign o_stat.adv_ok     = w_adv_ok;
    assign o_stat.mod_needed = (r_op != smrr_pkg::OP_RAW);

    // shared 32x32 multiplier, operand select per partial product
    assign w_k = i_cmd.mul_b ? smrr_pkg::MIX_MUL_B : smrr_pkg::MIX_MUL_A;

    always_comb begin
        case (i_cmd.mul_step)
            2'd0: begin
                w_mul_x = r_z[31:0];
                w_mul_y = w_k[31:0];
            end
            2'd1: begin
                w_mul_x = r_z[63:32];
                w_mul_y = w_k[31:0];
            end
            default: begin
                w_mul_x = r_z[31:0];
                w_mul_y = w_k[63:32];
            end
        endcase
    end

    assign w_prod = 64'(w_mul_x) * 64'(w_mul_y);

    // one restoring remainder step
    assign w_trial = {r_rem[30:0], r_dvd[63]};
    assign w_ge    = (w_trial >= r_div);

    // final ranged value
    always_comb begin
        if (!r_adv) begin
            w_ranged = (r_op == smrr_pkg::OP_RANGE) ? r_lo : 32'd0;
        end else begin
            case (r_op)
                smrr_pkg::OP_BOUND: w_ranged = r_rem;
                smrr_pkg::OP_RANGE: w_ranged = r_lo + r_rem;
                default:            w_ranged = 32'd0;
            endcase
        end
    end

    // generator state: seed load and golden increment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= 64'd0;
        end else if (i_cfg_we) begin
            r_state <= i_cfg_wdata;
        end else if (i_cmd.adv) begin
            r_state <= r_state + smrr_pkg::GOLDEN_INC;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_in.operation;
            r_adv <= w_adv_ok;
            r_lo  <= 32'(i_in.range_low);
            r_div <= (i_in.operation == smrr_pkg::OP_BOUND) ? 32'(i_in.bound_count) : w_span;
        end
    end

    // mixer: xor-shift stages and partial product accumulation
    always_ff @(posedge i_clk) begin
        if (i_cmd.pre) begin
            r_z <= r_state ^ (r_state >> smrr_pkg::SHIFT_PRE);
        end else if (i_cmd.mid) begin
            r_z <= r_acc ^ (r_acc >> smrr_pkg::SHIFT_MID);
        end
        if (i_cmd.mul_a || i_cmd.mul_b) begin
            r_prod <= w_prod;
            case (i_cmd.mul_step)
                2'd0:    r_acc <= r_acc;
                2'd1:    r_acc <= r_prod;
                default: r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
            endcase
        end
        if (i_cmd.post) begin
            r_word <= r_acc ^ (r_acc >> smrr_pkg::SHIFT_POST);
        end
    end

    // remainder unit
    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_dvd <= r_acc ^ (r_acc >> smrr_pkg::SHIFT_POST);
            r_rem <= 32'd0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[62:0], 1'b0};
            r_rem <= w_ge ? (w_trial - r_div) : w_trial;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.raw_word     <= r_adv ? r_word : 64'd0;
            r_out.ranged_value <= $signed(w_ranged);
        end
    end

    assign o_out = r_out;

endmodule

### hdl/smrr_ctrl.sv
module smrr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_stall,
    input  smrr_pkg::t_stat  i_stat,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output smrr_pkg::t_cmd   o_cmd
);

    smrr_pkg::t_state r_state;
    smrr_pkg::t_state n_state;
    logic [smrr_pkg::CNT_W-1:0] r_cnt;
    logic [smrr_pkg::CNT_W-1:0] n_cnt;
    logic r_out_valid;
    logic n_out_valid;

    logic w_last_mul;
    logic w_last_div;
    logic w_out_free;

    assign w_last_mul = (r_cnt == smrr_pkg::CNT_W'(smrr_pkg::MUL_STEPS - 1));
    assign w_last_div = (r_cnt == smrr_pkg::CNT_W'(smrr_pkg::DIV_STEPS - 1));
    assign w_out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            smrr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.adv_ok ? smrr_pkg::S_ADV : smrr_pkg::S_DONE;
                end
            end
            smrr_pkg::S_ADV:  n_state = smrr_pkg::S_PRE;
            smrr_pkg::S_PRE:  n_state = smrr_pkg::S_MULA;
            smrr_pkg::S_MULA: begin
                if (w_last_mul) begin
                    n_state = smrr_pkg::S_MID;
                end
            end
            smrr_pkg::S_MID:  n_state = smrr_pkg::S_MULB;
            smrr_pkg::S_MULB: begin
                if (w_last_mul) begin
                    n_state = smrr_pkg::S_POST;
                end
            end
            smrr_pkg::S_POST: begin
                n_state = i_stat.mod_needed ? smrr_pkg::S_DIV : smrr_pkg::S_DONE;
            end
            smrr_pkg::S_DIV: begin
                if (w_last_div) begin
                    n_state = smrr_pkg::S_DONE;
                end
            end
            smrr_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = smrr_pkg::S_IDLE;
                end
            end
            default: n_state = smrr_pkg::S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_step = r_cnt[1:0];
        case (r_state)
            smrr_pkg::S_IDLE: o_cmd.accept   = i_in_valid;
            smrr_pkg::S_ADV:  o_cmd.adv      = 1'b1;
            smrr_pkg::S_PRE:  o_cmd.pre      = 1'b1;
            smrr_pkg::S_MULA: o_cmd.mul_a    = 1'b1;
            smrr_pkg::S_MID:  o_cmd.mid      = 1'b1;
            smrr_pkg::S_MULB: o_cmd.mul_b    = 1'b1;
            smrr_pkg::S_POST: o_cmd.post     = 1'b1;
            smrr_pkg::S_DIV:  o_cmd.div_step = 1'b1;
            smrr_pkg::S_DONE: o_cmd.load_out = w_out_free;
            default:          o_cmd.accept   = 1'b0;
        endcase
    end

    // step counter for multiply and remainder passes
    always_comb begin
        n_cnt = '0;
        if (r_state inside {smrr_pkg::S_MULA, smrr_pkg::S_MULB}) begin
            n_cnt = w_last_mul ? '0 : r_cnt + 1'b1;
        end else if (r_state == smrr_pkg::S_DIV) begin
            n_cnt = w_last_div ? '0 : r_cnt + 1'b1;
        end
    end

    // output beat valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smrr_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != smrr_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### hdl/splitmix64_ranged_random.sv
// splitmix64 generator with raw, bounded and ranged draws
//
// input channel: i_in_valid / o_in_stall carry one request beat (operation,
// bound_count, range_low, range_high). output channel: o_out_valid /
// i_out_stall carry one result beat (raw_word, ranged_value) per request.
// i_cfg_we with i_cfg_wdata loads the seed straight into the generator
// state; write it only while no request is in flight.
//
// one request is worked on at a time. a raw draw runs two 64-bit
// multiplies, each done as three 32x32 partial products on one shared
// multiplier. a bounded or ranged draw adds a pass of the radix-2
// remainder unit over the 64-bit word. a draw that does not advance
// the state (count not positive, operation 3) skips the mixer and goes
// straight to its result. the next request is taken in the cycle after
// the result enters the output register.
//
// reset clears the generator state to zero and empties the output register.
// while the receiver stalls, the result holds and one further request can
// be taken and run up to its result, which then waits for the register.
module splitmix64_ranged_random (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [63:0]     i_cfg_wdata,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  smrr_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output smrr_pkg::t_out  o_out
);

    smrr_pkg::t_cmd  w_cmd;
    smrr_pkg::t_stat w_stat;

    // sequencer
    smrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // generator, mixer and remainder unit
    smrr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out       (o_out)
    );

endmodule

### hdl/smrr_checker.sv
`include "splitmix64_ranged_random_assert.svh"

module smrr_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input smrr_pkg::t_out  o_out
);

    // a stalled result beat stays valid and unchanged
    `SMRR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `SMRR_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out))

    // an accepted request raises the input stall and so blocks the next one
    `SMRR_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a result only appears from a request in flight
    `SMRR_ASSERT_IMP(a_out_from_req, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind splitmix64_ranged_random smrr_checker u_smrr_checker (.*);
